/* design/slip_pkg.sv */
// Shared types and constants for the slope-intercept line plotter.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none
package slip_pkg;

    localparam int COORD_W   = 13;
    localparam int FRAC_BITS = 8;
    localparam int COL_OUT_W = 5;
    localparam int ROW_OUT_W = 5;
    localparam int STAT_W    = 2;

    // slope divider: |dy| << 16 over |dx|, two quotient bits per cycle
    localparam int DIV_BITS      = 30;
    localparam int DIV_STEP_BITS = 2;
    localparam int DIV_CYCLES    = DIV_BITS / DIV_STEP_BITS;
    localparam int DIV_CNT_W     = $clog2(DIV_CYCLES);
    localparam int REM_W         = COORD_W + 1;

    // Q.16 accumulator for y, wide enough for 31 steps of the steepest slope
    localparam int Y_W      = 38;
    localparam int ONE_Q16  = 65536;
    localparam int COL_W    = 7;

    localparam int RESULT_CAP = 34;
    localparam int RUN_CAP    = RESULT_CAP - 3;
    localparam int RUN_CNT_W  = 5;

    localparam logic [STAT_W-1:0] ST_PIXEL     = 2'd0;
    localparam logic [STAT_W-1:0] ST_VERTICAL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_LEFT_GRID = 2'd2;

    localparam logic [2:0] K_START = 3'd0;
    localparam logic [2:0] K_END   = 3'd1;
    localparam logic [2:0] K_RUN   = 3'd2;
    localparam logic [2:0] K_LEAVE = 3'd3;
    localparam logic [2:0] K_VERT  = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
    } seg_t;

    typedef struct packed {
        logic [COL_OUT_W-1:0] column;
        logic [ROW_OUT_W-1:0] row;
        logic [STAT_W-1:0]    status;
        logic                 last;
    } res_t;

    typedef struct packed {
        logic       load;
        logic       div_step;
        logic       finish;
        logic       step;
        logic       emit;
        logic [2:0] kind;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic vertical;
        logic y0_lt;
        logic ynext_lt;
        logic col_ge;
    } stat_t;

endpackage
`default_nettype wire

/* design/slope_intercept_line_plotter_core.sv */
// Slope-intercept line plotter: top level joining controller and datapath.
// Depends on slip_pkg, slip_ctrl, slip_datapath.
// Per segment: radix-4 slope divide, then start point, end point and run pixels.
// A new request is taken only when idle (busy low); a vertical segment is answered from idle.
// Results come one per clock from the registered output; the receiver cannot stall.
// Reset (rst_n, async low) returns the controller to idle and drops the strobe.
`default_nettype none
module slope_intercept_line_plotter_core
#(
    parameter int GRID_SIZE = 32
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  slip_pkg::seg_t       segment,
    output slip_pkg::res_t       result,
    output logic                 strobe
);

    slip_pkg::cmd_t  cmd;
    slip_pkg::stat_t stat;

    slip_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    slip_datapath #(.GRID_SIZE(GRID_SIZE)) u_dp
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .segment (segment),
        .cmd     (cmd),
        .stat    (stat),
        .result  (result),
        .strobe  (strobe)
    );

endmodule
`default_nettype wire

/* design/slip_ctrl.sv */
// Controller state machine for the line plotter: sequences divide, endpoints, run.
// Depends on slip_pkg; drives slip_datapath through cmd_t, reads stat_t.
`default_nettype none
module slip_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  slip_pkg::stat_t      stat,
    output slip_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIV    = 3'd1;
    localparam logic [2:0] S_EMIT_S = 3'd2;
    localparam logic [2:0] S_EMIT_E = 3'd3;
    localparam logic [2:0] S_RUN    = 3'd4;

    logic [2:0]                       state_reg, state_next;
    logic [slip_pkg::DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic [slip_pkg::RUN_CNT_W-1:0]   run_cnt_reg, run_cnt_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        run_cnt_next = run_cnt_reg;
        cmd          = '0;
        cmd.kind     = slip_pkg::K_START;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (stat.vertical)
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = slip_pkg::K_VERT;
                        cmd.last = 1'b1;
                    end
                    else
                    begin
                        cmd.load     = 1'b1;
                        div_cnt_next = '0;
                        state_next   = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == slip_pkg::DIV_CNT_W'(slip_pkg::DIV_CYCLES - 1))
                    state_next = S_EMIT_S;
            end
            S_EMIT_S:
            begin
                cmd.emit   = 1'b1;
                cmd.finish = 1'b1;
                cmd.kind   = slip_pkg::K_START;
                state_next = S_EMIT_E;
            end
            S_EMIT_E:
            begin
                cmd.emit     = 1'b1;
                cmd.kind     = slip_pkg::K_END;
                cmd.last     = !stat.y0_lt;
                run_cnt_next = '0;
                state_next   = stat.y0_lt ? S_RUN : S_IDLE;
            end
            S_RUN:
            begin
                cmd.emit = 1'b1;
                // run is known to continue here; decide pixel or leave-grid marker
                if (stat.col_ge ||
                    run_cnt_reg == slip_pkg::RUN_CNT_W'(slip_pkg::RUN_CAP))
                begin
                    cmd.kind   = slip_pkg::K_LEAVE;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.kind     = slip_pkg::K_RUN;
                    cmd.last     = !stat.ynext_lt;
                    cmd.step     = 1'b1;
                    run_cnt_next = run_cnt_reg + 1'b1;
                    if (!stat.ynext_lt)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            div_cnt_reg <= '0;
            run_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            run_cnt_reg <= run_cnt_next;
        end
    end

endmodule
`default_nettype wire

/* design/slip_datapath.sv */
// Datapath for the line plotter: slope divider, y accumulator, row/column logic,
// result register. Depends on slip_pkg; controlled by slip_ctrl via cmd_t.
`default_nettype none
module slip_datapath
#(
    parameter int GRID_SIZE = 32
)
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  slip_pkg::seg_t       segment,
    input  slip_pkg::cmd_t       cmd,
    output slip_pkg::stat_t      stat,
    output slip_pkg::res_t       result,
    output logic                 strobe
);

    localparam int CW = slip_pkg::COORD_W;
    localparam int YW = slip_pkg::Y_W;
    localparam int DB = slip_pkg::DIV_BITS;
    localparam int RW = slip_pkg::REM_W;
    localparam int HW = YW - 16;

    localparam logic signed [YW-1:0]        GRID_Q16 = YW'(GRID_SIZE * 65536);
    localparam logic signed [15:0]          GRID_Q8  = 16'(GRID_SIZE * 256);
    localparam logic signed [YW-1:0]        ONE      = YW'(slip_pkg::ONE_Q16);
    localparam logic [slip_pkg::COL_W-1:0]  GRID_C   = slip_pkg::COL_W'(GRID_SIZE);
    localparam logic [slip_pkg::COL_W-1:0]  MAX_C    = slip_pkg::COL_W'(GRID_SIZE - 1);
    localparam logic [HW-1:0]               MAX_H    = HW'(GRID_SIZE - 1);

    logic [CW-1:0]                ys_reg, ye_reg;
    logic [4:0]                   xs_col_reg, xe_col_reg;
    logic                         neg_reg;
    logic [CW-1:0]                den_reg;
    logic [DB-1:0]                num_reg, num_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic [DB-1:0]                quo_reg, quo_next;
    logic signed [YW-1:0]         slope_reg;
    logic signed [YW-1:0]         y_reg, limit_reg;
    logic [slip_pkg::COL_W-1:0]   col_reg;
    slip_pkg::res_t               res_reg, res_next;
    logic                         strobe_reg;

    logic signed [CW:0]           dx, dy;
    logic [CW-1:0]                abs_dx, abs_dy;
    logic signed [YW-1:0]         y_next;

    // ---- segment capture ----
    always_comb
    begin
        dx     = $signed({1'b0, segment.x_end}) - $signed({1'b0, segment.x_start});
        dy     = $signed({1'b0, segment.y_end}) - $signed({1'b0, segment.y_start});
        abs_dx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
        abs_dy = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    end

    // ---- restoring divider, DIV_STEP_BITS quotient bits per cycle ----
    always_comb
    begin
        rem_next = rem_reg;
        num_next = num_reg;
        quo_next = quo_reg;
        for (int i = 0; i < slip_pkg::DIV_STEP_BITS; i++)
        begin
            rem_next = {rem_next[RW-2:0], num_next[DB-1]};
            num_next = {num_next[DB-2:0], 1'b0};
            if (rem_next >= {1'b0, den_reg})
            begin
                rem_next = rem_next - {1'b0, den_reg};
                quo_next = {quo_next[DB-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_next[DB-2:0], 1'b0};
            end
        end
    end

    assign y_next = y_reg + slope_reg;

    always_comb
    begin
        stat.vertical = (segment.x_start == segment.x_end);
        stat.y0_lt    = (y_reg < limit_reg);
        stat.ynext_lt = (y_next < limit_reg);
        stat.col_ge   = (col_reg >= GRID_C);
    end

    // ---- row and column for each result kind ----
    function automatic logic [4:0] row_q8(input logic [CW-1:0] yv);
        logic signed [15:0] v;
        logic [7:0]         r;
        v = GRID_Q8 - $signed({3'b000, yv});
        r = v[15:8];
        if (v[15])
            return 5'd0;
        else if (HW'(r) > MAX_H)
            return MAX_H[4:0];
        else
            return r[4:0];
    endfunction

    function automatic logic [4:0] sat_col(input logic [4:0] c);
        if (slip_pkg::COL_W'(c) > MAX_C)
            return MAX_C[4:0];
        else
            return c;
    endfunction

    logic signed [YW-1:0] v_run;
    logic [4:0]           row_run;

    always_comb
    begin
        v_run = GRID_Q16 - y_reg;
        if (v_run[YW-1])
            row_run = 5'd0;
        else if (v_run[YW-1:16] > MAX_H)
            row_run = MAX_H[4:0];
        else
            row_run = v_run[20:16];
    end

    always_comb
    begin
        res_next = res_reg;
        unique case (cmd.kind)
            slip_pkg::K_START:
            begin
                res_next.column = sat_col(xs_col_reg);
                res_next.row    = row_q8(ys_reg);
                res_next.status = slip_pkg::ST_PIXEL;
            end
            slip_pkg::K_END:
            begin
                res_next.column = sat_col(xe_col_reg);
                res_next.row    = row_q8(ye_reg);
                res_next.status = slip_pkg::ST_PIXEL;
            end
            slip_pkg::K_RUN:
            begin
                res_next.column = col_reg[4:0];
                res_next.row    = row_run;
                res_next.status = slip_pkg::ST_PIXEL;
            end
            slip_pkg::K_LEAVE:
            begin
                res_next.column = '0;
                res_next.row    = '0;
                res_next.status = slip_pkg::ST_LEFT_GRID;
            end
            default:
            begin
                res_next.column = '0;
                res_next.row    = '0;
                res_next.status = slip_pkg::ST_VERTICAL;
            end
        endcase
        res_next.last = cmd.last;
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ys_reg     <= segment.y_start;
            ye_reg     <= segment.y_end;
            xs_col_reg <= segment.x_start[CW-1:slip_pkg::FRAC_BITS];
            xe_col_reg <= segment.x_end[CW-1:slip_pkg::FRAC_BITS];
            neg_reg    <= dx[CW] ^ dy[CW];
            den_reg    <= abs_dx;
            num_reg    <= {1'b0, abs_dy, 16'd0};
            rem_reg    <= '0;
            quo_reg    <= '0;
            y_reg      <= $signed({{(YW-CW-8){1'b0}}, segment.y_start, 8'd0});
            limit_reg  <= $signed({{(YW-CW-8){1'b0}}, segment.y_end, 8'd0}) - ONE;
            col_reg    <= slip_pkg::COL_W'(segment.x_start[CW-1:slip_pkg::FRAC_BITS]);
        end
        else
        begin
            if (cmd.div_step)
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
            if (cmd.finish)
                slope_reg <= neg_reg ? -$signed({{(YW-DB){1'b0}}, quo_reg})
                                     :  $signed({{(YW-DB){1'b0}}, quo_reg});
            if (cmd.step)
            begin
                y_reg   <= y_next;
                col_reg <= col_reg + 1'b1;
            end
        end
        if (cmd.emit)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit;
    end

    assign result = res_reg;
    assign strobe = strobe_reg;

endmodule
`default_nettype wire

/* design/slip_checker.sv */
// Port-level checker for the line plotter, bound to the top level.
// Depends on slip_pkg and slope_intercept_line_plotter_core.
`default_nettype none
module slip_checker
(
    input wire             clk,
    input wire             rst_n,
    input wire             start,
    input wire             busy,
    input slip_pkg::res_t  result,
    input wire             strobe
);

    // an accepted request either starts work or answers at once
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || (strobe && result.last)))
        else $error("request neither started nor answered");

    // only pixels may be followed by more results
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.status != slip_pkg::ST_PIXEL) |-> result.last)
        else $error("non-pixel result without last");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (result.status == slip_pkg::ST_PIXEL ||
                    result.status == slip_pkg::ST_VERTICAL ||
                    result.status == slip_pkg::ST_LEFT_GRID))
        else $error("bad status code");

    a_more: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |-> busy)
        else $error("idle while results remain");

    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (strobe && result.last))
        else $error("work ended without final result");

endmodule

bind slope_intercept_line_plotter_core slip_checker u_slip_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .result (result),
    .strobe (strobe)
);
`default_nettype wire
